>>> rtl/ffba_pkg.sv
// Shared constants, status codes and controller/datapath interface types
// for the first-fit block allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

    localparam int NUM_PAGES       = 4;
    localparam int PAGE_BYTES      = 4096;
    localparam int MIN_ALLOC       = 256;
    localparam int BLOCKS_PER_PAGE = PAGE_BYTES / MIN_ALLOC;
    localparam int TOTAL_BLOCKS    = NUM_PAGES * BLOCKS_PER_PAGE;

    localparam int IDX_W   = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
    localparam int LEN_W   = $clog2(BLOCKS_PER_PAGE + 1);
    localparam int BYTES_W = 16;
    localparam int ADDR_W  = 14;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic              capture;
        logic              scan_init;
        logic              scan_step;
        logic              mark_init;
        logic              mark_step;
        logic              set_len;
        logic              free_init;
        logic              clear_step;
        logic              drop_len;
        logic              load_result;
        logic [STAT_W-1:0] res_status;
        logic              res_grant;
    } ffba_cmd_t;

    typedef struct packed {
        logic is_free;
        logic bad_size;
        logic too_big;
        logic addr_bad;
        logic hit;
        logic scan_last;
        logic mark_last;
        logic len_zero;
        logic clear_last;
    } ffba_stat_t;

endpackage
`default_nettype wire

>>> rtl/ffba_ctrl.sv
// Sequencing state machine of the first-fit block allocator.
// Depends on ffba_pkg; drives ffba_dp through command/status structs.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    output ffba_pkg::ffba_cmd_t      cmd,
    input  wire ffba_pkg::ffba_stat_t stat
);
    import ffba_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_MARK   = 3'd3;
    localparam logic [2:0] S_FCHK   = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.is_free)
                begin
                    if (stat.bad_size)
                    begin
                        cmd.load_result = 1'b1;
                        cmd.res_status  = ST_BAD_SIZE;
                        state_next      = S_IDLE;
                    end
                    else if (stat.too_big)
                    begin
                        cmd.load_result = 1'b1;
                        cmd.res_status  = ST_NO_SPACE;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
                else if (stat.addr_bad)
                begin
                    cmd.load_result = 1'b1;
                    cmd.res_status  = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.free_init = 1'b1;
                    state_next    = S_FCHK;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.mark_init = 1'b1;
                    state_next    = S_MARK;
                end
                else if (stat.scan_last)
                begin
                    cmd.load_result = 1'b1;
                    cmd.res_status  = ST_NO_SPACE;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (stat.mark_last)
                begin
                    cmd.set_len     = 1'b1;
                    cmd.load_result = 1'b1;
                    cmd.res_status  = ST_OK;
                    cmd.res_grant   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_FCHK:
            begin
                if (stat.len_zero)
                begin
                    cmd.load_result = 1'b1;
                    cmd.res_status  = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    cmd.drop_len    = 1'b1;
                    cmd.load_result = 1'b1;
                    cmd.res_status  = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/ffba_dp.sv
// Datapath of the first-fit block allocator: used bitmap, run length
// memory with valid bits, scan/mark/clear counters and result registers.
// Depends on ffba_pkg; commanded by ffba_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module ffba_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ffba_pkg::ffba_cmd_t           cmd,
    output ffba_pkg::ffba_stat_t               stat,
    input  wire logic                          action,
    input  wire logic [ffba_pkg::BYTES_W-1:0]  request_bytes,
    input  wire logic [ffba_pkg::ADDR_W-1:0]   free_address,
    output logic                               done,
    output logic [ffba_pkg::STAT_W-1:0]        status,
    output logic [ffba_pkg::ADDR_W-1:0]        granted_address
);
    import ffba_pkg::*;

    logic                    action_reg;
    logic [BYTES_W-1:0]      bytes_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [LEN_W-1:0]        need_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [LEN_W-1:0]        run_reg;
    logic [IDX_W-1:0]        ptr_reg;
    logic [IDX_W-1:0]        first_reg;
    logic [LEN_W-1:0]        cnt_reg;
    logic [TOTAL_BLOCKS-1:0] used_reg;
    logic [TOTAL_BLOCKS-1:0] lvalid_reg;
    logic [LEN_W-1:0]        len_mem [TOTAL_BLOCKS];
    logic [LEN_W-1:0]        rdata_reg;
    logic                    rvalid_reg;
    logic                    done_reg;
    logic [STAT_W-1:0]       status_reg;
    logic [ADDR_W-1:0]       grant_reg;

    logic [31:0]      need32;
    logic [31:0]      fpage32;
    logic [31:0]      foff32;
    logic [31:0]      fblk32;
    logic [IDX_W-1:0] ftarget;
    logic [LEN_W-1:0] run_eff;
    logic             blk_free;
    logic [LEN_W-1:0] len_cur;
    logic [31:0]      gaddr32;

    assign need32  = 32'(bytes_reg) / MIN_ALLOC;
    assign fpage32 = 32'(addr_reg) / PAGE_BYTES;
    assign foff32  = 32'(addr_reg) % PAGE_BYTES;
    assign fblk32  = foff32 / MIN_ALLOC;
    assign ftarget = IDX_W'(fpage32 * BLOCKS_PER_PAGE + fblk32);

    assign blk_free = !used_reg[idx_reg];
    assign run_eff  = ((32'(idx_reg) % BLOCKS_PER_PAGE) == 0) ? '0 : run_reg;
    assign len_cur  = rvalid_reg ? rdata_reg : '0;

    assign gaddr32 = (32'(first_reg) / BLOCKS_PER_PAGE) * PAGE_BYTES
                   + (32'(first_reg) % BLOCKS_PER_PAGE) * MIN_ALLOC;

    always_comb
    begin
        stat.is_free    = (action_reg == ACT_FREE);
        stat.bad_size   = (bytes_reg == '0) || ((32'(bytes_reg) % MIN_ALLOC) != 0);
        stat.too_big    = (need32 > BLOCKS_PER_PAGE);
        stat.addr_bad   = (fpage32 >= NUM_PAGES) || ((foff32 % MIN_ALLOC) != 0)
                       || (fblk32 >= BLOCKS_PER_PAGE);
        stat.hit        = blk_free && ((run_eff + 1'b1) == need_reg);
        stat.scan_last  = (32'(idx_reg) == TOTAL_BLOCKS - 1);
        stat.mark_last  = ((cnt_reg + 1'b1) == need_reg);
        stat.len_zero   = (len_cur == '0);
        stat.clear_last = ((cnt_reg + 1'b1) == len_cur)
                       || ((32'(ptr_reg) % BLOCKS_PER_PAGE) == BLOCKS_PER_PAGE - 1);
    end

    // request word and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            bytes_reg  <= request_bytes;
            addr_reg   <= free_address;
        end
        if (cmd.scan_init)
        begin
            need_reg <= LEN_W'(need32);
            idx_reg  <= '0;
            run_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            run_reg <= blk_free ? run_eff + 1'b1 : '0;
        end
        if (cmd.mark_init)
        begin
            ptr_reg   <= IDX_W'(32'(idx_reg) + 1 - 32'(need_reg));
            first_reg <= IDX_W'(32'(idx_reg) + 1 - 32'(need_reg));
            cnt_reg   <= '0;
        end
        else if (cmd.free_init)
        begin
            ptr_reg   <= ftarget;
            first_reg <= ftarget;
            cnt_reg   <= '0;
        end
        else if (cmd.mark_step || cmd.clear_step)
        begin
            ptr_reg <= ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // run length memory
    always_ff @(posedge clk)
    begin
        if (cmd.set_len)
        begin
            len_mem[first_reg] <= need_reg;
        end
        if (cmd.free_init)
        begin
            rdata_reg <= len_mem[ftarget];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            lvalid_reg <= '0;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.mark_step)
            begin
                used_reg[ptr_reg] <= 1'b1;
            end
            else if (cmd.clear_step)
            begin
                used_reg[ptr_reg] <= 1'b0;
            end
            if (cmd.set_len)
            begin
                lvalid_reg[first_reg] <= 1'b1;
            end
            else if (cmd.drop_len)
            begin
                lvalid_reg[first_reg] <= 1'b0;
            end
            if (cmd.free_init)
            begin
                rvalid_reg <= lvalid_reg[ftarget];
            end
            done_reg <= cmd.load_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            status_reg <= cmd.res_status;
            grant_reg  <= cmd.res_grant ? gaddr32[ADDR_W-1:0] : '0;
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_address = grant_reg;

endmodule
`default_nettype wire

>>> rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: controller plus datapath.
// Depends on ffba_pkg, ffba_ctrl and ffba_dp.
//
//   channel  | handshake         | words
//   ---------+-------------------+-----------------------------------------
//   request  | start & !busy     | action, request_bytes, free_address
//   result   | done (one cycle)  | status, granted_address
//
// Allocate: a bad size or oversize request is answered from decode; else the
// used bitmap is scanned to the fit and the run (at most 16 blocks) is marked.
// Free: a bad address is answered from decode; else the stored run length is
// checked and its blocks cleared. The one-block-per-cycle scan of the used
// bitmap sets the allocate time. done is high in the first cycle with busy low.
// Asynchronous reset frees every block and invalidates all run lengths at once.
// The receiver cannot stall; a result is shown for a single cycle.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          action,
    input  wire logic [ffba_pkg::BYTES_W-1:0]  request_bytes,
    input  wire logic [ffba_pkg::ADDR_W-1:0]   free_address,
    output logic                               done,
    output logic [ffba_pkg::STAT_W-1:0]        status,
    output logic [ffba_pkg::ADDR_W-1:0]        granted_address
);
    import ffba_pkg::*;

    ffba_cmd_t  cmd;
    ffba_stat_t stat;

    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    ffba_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .action          (action),
        .request_bytes   (request_bytes),
        .free_address    (free_address),
        .done            (done),
        .status          (status),
        .granted_address (granted_address)
    );

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not raise busy");

    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (granted_address == '0))
        else $error("nonzero address on failed request");

    a_grant_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((32'(granted_address) % MIN_ALLOC) == 0))
        else $error("granted address not block aligned");
`endif

endmodule
`default_nettype wire
